>>> src/chm_pkg.sv
package chm_pkg;

    // Datapath widths
    localparam int IN_W     = 16;
    localparam int XW       = 34;   // CORDIC x/y: 17-bit magnitude << 14, plus gain headroom
    localparam int ZW       = 33;   // angle accumulator, 2^-16 hundredths of a degree
    localparam int RAW_W    = 17;   // rounded raw angle, hundredths
    localparam int SUM_W    = 18;   // raw angle plus declination
    localparam int PRESCALE = 14;
    localparam int TABLE_LEN = 24;

    // Angle constants
    localparam logic signed [ZW-1:0]    HALF_TURN_UNITS = 33'sd1179648000;
    localparam logic signed [ZW-1:0]    ROUND_HALF      = 33'sd32768;
    localparam logic signed [RAW_W-1:0] RAW_HALF        = 17'sd18000;
    localparam logic signed [RAW_W-1:0] RAW_FULL        = 17'sd36000;
    localparam logic signed [SUM_W-1:0] SUM_FULL        = 18'sd36000;
    localparam logic signed [SUM_W-1:0] SUM_TWO_FULL    = 18'sd72000;
    localparam logic [15:0]             FULL_CIRCLE     = 16'd36000;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_DECLINATION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND    = 2'd1;

    localparam logic signed [15:0] DECLINATION_RESET = 16'sd1261;
    localparam logic [14:0]        DEADBAND_RESET    = 15'd500;

    // atan(2^-i) in 2^-16 hundredths of a degree
    localparam logic signed [ZW-1:0] ATAN_UNITS [0:TABLE_LEN-1] = '{
        33'sd294912000, 33'sd174096719, 33'sd91987925, 33'sd46694507,
        33'sd23437865,  33'sd11730358,  33'sd5866610,  33'sd2933484,
        33'sd1466764,   33'sd733385,    33'sd366693,   33'sd183346,
        33'sd91673,     33'sd45837,     33'sd22918,    33'sd11459,
        33'sd5730,      33'sd2865,      33'sd1432,     33'sd716,
        33'sd358,       33'sd179,       33'sd90,       33'sd45
    };

endpackage

>>> src/compass_heading_from_magnetometer_core.sv
// Registers from input accept to out_valid, in order: prescale, one per
//   CORDIC stage, round, declination, compare.
// Throughput: one item per cycle unless out_stall holds a result; every stage holds
//   its own valid bit and refills as soon as it empties, so bubbles close up under out_stall.
// Reset (rst_n low, asynchronous): all valid bits clear, declination returns
//   to 1261 and deadband to 500. cfg_ready is always high.
module compass_heading_from_magnetometer_core #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // sample channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [15:0]                 field_x,
    input  logic signed [15:0]                 field_y,
    input  logic [15:0]                        target_heading,
    // result channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [15:0]                        heading_out,
    output logic                               target_reached,
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [chm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [15:0]                        cfg_data
);

    localparam int NS = (CORDIC_STAGES > chm_pkg::TABLE_LEN) ? chm_pkg::TABLE_LEN
                                                             : CORDIC_STAGES;
    localparam int ST_RND = NS + 1;
    localparam int ST_DEC = NS + 2;
    localparam int ST_OUT = NS + 3;

    // Configuration registers
    logic signed [15:0] decl_reg;
    logic [14:0]        deadband_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decl_reg     <= chm_pkg::DECLINATION_RESET;
            deadband_reg <= chm_pkg::DEADBAND_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                chm_pkg::REG_DECLINATION: decl_reg     <= $signed(cfg_data);
                chm_pkg::REG_DEADBAND:    deadband_reg <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // Valid bits and per-stage ready (bubble collapsing)
    logic [ST_OUT:0] v_reg;
    logic [ST_OUT:0] ready;

    always_comb
    begin
        ready[ST_OUT] = !v_reg[ST_OUT] || !out_stall;
        for (int k = ST_OUT - 1; k >= 0; k--)
        begin
            ready[k] = !v_reg[k] || ready[k+1];
        end
    end

    assign in_stall = !ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (ready[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k <= ST_OUT; k++)
            begin
                if (ready[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // Payload registers along the CORDIC part
    logic signed [chm_pkg::XW-1:0] x_reg [0:NS];
    logic signed [chm_pkg::XW-1:0] y_reg [0:NS];
    logic signed [chm_pkg::ZW-1:0] z_reg [0:NS];
    logic                          zero_reg [0:NS];
    logic [15:0]                   tgt_reg [0:ST_DEC];

    // Prescale stage: fold left half plane, scale by 2^14
    logic signed [16:0]             x_ext;
    logic signed [16:0]             y_ext;
    logic signed [16:0]             x_abs;
    logic signed [16:0]             y_fold;
    logic signed [chm_pkg::XW-1:0]  x_next;
    logic signed [chm_pkg::XW-1:0]  y_next;
    logic signed [chm_pkg::ZW-1:0]  z_next;

    always_comb
    begin
        x_ext  = {field_x[15], field_x};
        y_ext  = {field_y[15], field_y};
        x_abs  = field_x[15] ? -x_ext : x_ext;
        y_fold = field_x[15] ? -y_ext : y_ext;
        x_next = {{(chm_pkg::XW - 17 - chm_pkg::PRESCALE){x_abs[16]}}, x_abs,
                  {chm_pkg::PRESCALE{1'b0}}};
        y_next = {{(chm_pkg::XW - 17 - chm_pkg::PRESCALE){y_fold[16]}}, y_fold,
                  {chm_pkg::PRESCALE{1'b0}}};
        z_next = field_x[15] ? chm_pkg::HALF_TURN_UNITS : '0;
    end

    always_ff @(posedge clk)
    begin
        if (ready[0])
        begin
            x_reg[0]    <= x_next;
            y_reg[0]    <= y_next;
            z_reg[0]    <= z_next;
            zero_reg[0] <= (field_x == 16'sd0) && (field_y == 16'sd0);
            tgt_reg[0]  <= target_heading;
        end
    end

    // CORDIC vectoring stages, one register each
    for (genvar g = 0; g < NS; g++)
    begin : g_cordic
        logic signed [chm_pkg::XW-1:0] xs;
        logic signed [chm_pkg::XW-1:0] ys;

        assign xs = x_reg[g] >>> g;
        assign ys = y_reg[g] >>> g;

        always_ff @(posedge clk)
        begin
            if (ready[g+1])
            begin
                if (!y_reg[g][chm_pkg::XW-1])
                begin
                    x_reg[g+1] <= x_reg[g] + ys;
                    y_reg[g+1] <= y_reg[g] - xs;
                    z_reg[g+1] <= z_reg[g] + chm_pkg::ATAN_UNITS[g];
                end
                else
                begin
                    x_reg[g+1] <= x_reg[g] - ys;
                    y_reg[g+1] <= y_reg[g] + xs;
                    z_reg[g+1] <= z_reg[g] - chm_pkg::ATAN_UNITS[g];
                end
                zero_reg[g+1] <= zero_reg[g];
                tgt_reg[g+1]  <= tgt_reg[g];
            end
        end
    end

    // Round stage: to whole hundredths, halves up, into (-18000, 18000]
    logic signed [chm_pkg::ZW-1:0]    z_rnd;
    logic signed [chm_pkg::RAW_W-1:0] raw_pre;
    logic signed [chm_pkg::RAW_W-1:0] raw_next;
    logic signed [chm_pkg::RAW_W-1:0] raw_reg;

    always_comb
    begin
        z_rnd   = z_reg[NS] + chm_pkg::ROUND_HALF;
        raw_pre = z_rnd[chm_pkg::ZW-1:16];
        if (zero_reg[NS])
        begin
            raw_next = '0;
        end
        else if (raw_pre > chm_pkg::RAW_HALF)
        begin
            raw_next = raw_pre - chm_pkg::RAW_FULL;
        end
        else if (raw_pre <= -chm_pkg::RAW_HALF)
        begin
            raw_next = raw_pre + chm_pkg::RAW_FULL;
        end
        else
        begin
            raw_next = raw_pre;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[ST_RND])
        begin
            raw_reg         <= raw_next;
            tgt_reg[ST_RND] <= tgt_reg[NS];
        end
    end

    // Declination stage: add offset, wrap into 0..36000
    logic signed [chm_pkg::SUM_W-1:0] sum_pre;
    logic signed [chm_pkg::SUM_W-1:0] sum_wrap;
    logic [15:0]                      head_reg;

    always_comb
    begin
        sum_pre = {raw_reg[chm_pkg::RAW_W-1], raw_reg} + {{2{decl_reg[15]}}, decl_reg};
        if (sum_pre < -chm_pkg::SUM_FULL)
        begin
            sum_wrap = sum_pre + chm_pkg::SUM_TWO_FULL;
        end
        else if (sum_pre < 18'sd0)
        begin
            sum_wrap = sum_pre + chm_pkg::SUM_FULL;
        end
        else if (sum_pre > chm_pkg::SUM_FULL)
        begin
            sum_wrap = sum_pre - chm_pkg::SUM_FULL;
        end
        else
        begin
            sum_wrap = sum_pre;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[ST_DEC])
        begin
            head_reg        <= sum_wrap[15:0];
            tgt_reg[ST_DEC] <= tgt_reg[ST_RND];
        end
    end

    // Compare stage: plain absolute error against deadband
    logic signed [16:0] diff;
    logic [16:0]        diff_abs;
    logic [15:0]        heading_out_reg;
    logic               reached_reg;

    always_comb
    begin
        diff     = $signed({1'b0, head_reg}) - $signed({1'b0, tgt_reg[ST_DEC]});
        diff_abs = diff[16] ? $unsigned(-diff) : $unsigned(diff);
    end

    always_ff @(posedge clk)
    begin
        if (ready[ST_OUT])
        begin
            heading_out_reg <= head_reg;
            reached_reg     <= (diff_abs <= {2'b00, deadband_reg});
        end
    end

    assign out_valid      = v_reg[ST_OUT];
    assign heading_out    = heading_out_reg;
    assign target_reached = reached_reg;

endmodule

>>> src/chm_checker.sv
module chm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] heading_out,
    input logic        target_reached,
    input logic        cfg_ready
);

    // Heading always lands inside one turn
    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> heading_out <= chm_pkg::FULL_CIRCLE)
        else $error("heading_out above full circle");

    // Input only backs up when a result is held at the output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("in_stall without a stalled result");

    // Held result keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(heading_out)
                                      && $stable(target_reached)))
        else $error("stalled result changed");

    // An edge under reset empties the pipeline; config port never backpressures
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> (!out_valid && cfg_ready))
        else $error("output valid or cfg not ready after reset");

endmodule

bind compass_heading_from_magnetometer_core chm_checker u_chm_checker (.*);

>>> bench/heading_checker.sv
`timescale 1ns / 100ps

// Watches the sample, result and register channels of the compass core,
// predicts each heading at sample accept and checks results in order.
module heading_checker #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic signed [15:0]            field_x,
    input  logic signed [15:0]            field_y,
    input  logic [15:0]                   target_heading,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [15:0]                   heading_out,
    input  logic                          target_reached,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [chm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                   cfg_data,
    output int                            mismatches,
    output int                            pending,
    output int                            headings_checked,
    output int                            reached_seen
);

    localparam int     DECL_AT_RESET = 1261;
    localparam int     BAND_AT_RESET = 500;
    localparam int     MAX_STEPS     = 24;
    localparam longint HALF_TURN     = 64'sd1179648000;   // 18000 << 16
    localparam longint FULL_CIRCLE   = 36000;
    localparam int     REPORT_LIMIT  = 10;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [15:0]        target;
        logic [15:0]        heading;
        logic               reached;
    } heading_t;

    heading_t heading_q[$];
    heading_t oldest;
    int       decl_reg;
    int       band_reg;

    // atan(2^-i) in 2^-16 hundredths of a degree
    function automatic longint arctan_step(int i);
        case (i)
            0:  return 294912000;
            1:  return 174096719;
            2:  return 91987925;
            3:  return 46694507;
            4:  return 23437865;
            5:  return 11730358;
            6:  return 5866610;
            7:  return 2933484;
            8:  return 1466764;
            9:  return 733385;
            10: return 366693;
            11: return 183346;
            12: return 91673;
            13: return 45837;
            14: return 22918;
            15: return 11459;
            16: return 5730;
            17: return 2865;
            18: return 1432;
            19: return 716;
            20: return 358;
            21: return 179;
            22: return 90;
            default: return 45;
        endcase
    endfunction

    // CORDIC vectoring in 64-bit signed math; >>> floors like the hardware
    function automatic heading_t predict_heading(logic signed [15:0] sx, logic signed [15:0] sy,
                                                 logic [15:0] target);
        longint   x;
        longint   y;
        longint   z;
        longint   xs;
        longint   ys;
        longint   raw;
        longint   sum;
        longint   tgt;
        longint   diff;
        int       steps;
        heading_t res;
        x     = longint'(sx);
        y     = longint'(sy);
        tgt   = longint'(target);
        z     = 0;
        raw   = 0;
        steps = (CORDIC_STAGES < MAX_STEPS) ? CORDIC_STAGES : MAX_STEPS;
        if (x != 0 || y != 0)
        begin
            // left half plane: turn by 180 degrees first
            if (x < 0)
            begin
                x = -x;
                y = -y;
                z = HALF_TURN;
            end
            x = x * 16384;
            y = y * 16384;
            for (int i = 0; i < steps; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0)
                begin
                    x = x + ys;
                    y = y - xs;
                    z = z + arctan_step(i);
                end
                else
                begin
                    x = x - ys;
                    y = y + xs;
                    z = z - arctan_step(i);
                end
            end
            raw = (z + 32768) >>> 16;
            while (raw > FULL_CIRCLE / 2)
                raw = raw - FULL_CIRCLE;
            while (raw <= -FULL_CIRCLE / 2)
                raw = raw + FULL_CIRCLE;
        end
        // declination and wrap into 0..36000, 36000 kept as is
        sum = raw + longint'(decl_reg);
        while (sum < 0)
            sum = sum + FULL_CIRCLE;
        while (sum > FULL_CIRCLE)
            sum = sum - FULL_CIRCLE;
        // plain distance to target, no circular wrap
        diff = sum - tgt;
        if (diff < 0)
            diff = -diff;
        res.x       = sx;
        res.y       = sy;
        res.target  = target;
        res.heading = sum[15:0];
        res.reached = (diff <= longint'(band_reg));
        return res;
    endfunction

    task automatic note_mismatch(string what, int want, int got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t: %s mismatch: expected %0d, got %0d (x=%0d y=%0d target=%0d)",
                     $time, what, want, got, oldest.x, oldest.y, oldest.target);
    endtask

    // Channel monitor: results first, then register writes, then new samples
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heading_q.delete();
            decl_reg         = DECL_AT_RESET;
            band_reg         = BAND_AT_RESET;
            mismatches       = 0;
            pending          = 0;
            headings_checked = 0;
            reached_seen     = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (heading_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: unexpected result heading=%0d reached=%0d, none pending",
                                 $time, heading_out, target_reached);
                end
                else
                begin
                    oldest = heading_q.pop_front();
                    headings_checked++;
                    if (target_reached)
                        reached_seen++;
                    if (heading_out !== oldest.heading)
                        note_mismatch("heading_out", int'(oldest.heading), int'(heading_out));
                    if (target_reached !== oldest.reached)
                        note_mismatch("target_reached", int'(oldest.reached),
                                      int'(target_reached));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    chm_pkg::REG_DECLINATION: decl_reg = int'($signed(cfg_data));
                    chm_pkg::REG_DEADBAND:    band_reg = int'(cfg_data[14:0]);
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                heading_q.push_back(predict_heading(field_x, field_y, target_heading));
            pending = heading_q.size();
        end
    end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int CLK_PERIOD   = 10;
    localparam int DUT_LATENCY  = 19;          // DUT built with its default 16 CORDIC stages
    localparam int DRAIN_LIMIT  = 5000;
    localparam int PHASE_ITEMS  = 85;
    localparam logic [chm_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [chm_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    logic                          clk            = 1'b0;
    logic                          rst_n          = 1'b0;
    logic                          in_valid       = 1'b0;
    logic                          in_stall;
    logic signed [15:0]            field_x        = '0;
    logic signed [15:0]            field_y        = '0;
    logic [15:0]                   target_heading = '0;
    logic                          out_valid;
    logic                          out_stall      = 1'b0;
    logic [15:0]                   heading_out;
    logic                          target_reached;
    logic                          cfg_valid      = 1'b0;
    logic                          cfg_ready;
    logic [chm_pkg::CFG_IDX_W-1:0] cfg_index      = '0;
    logic [15:0]                   cfg_data       = '0;

    int mismatch_count;
    int pending;
    int headings_checked;
    int reached_seen;
    int samples_sent = 0;
    int settings_run = 1;
    int stall_mode   = 1;       // 0: never, 1: light, 2: heavy
    int stall_left   = 0;
    int stall_roll;
    bit quiet        = 1'b0;    // no sender gaps

    always #(CLK_PERIOD / 2) clk = ~clk;

    compass_heading_from_magnetometer_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .field_x        (field_x),
        .field_y        (field_y),
        .target_heading (target_heading),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .heading_out    (heading_out),
        .target_reached (target_reached),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    heading_checker i_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .field_x          (field_x),
        .field_y          (field_y),
        .target_heading   (target_heading),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .heading_out      (heading_out),
        .target_reached   (target_reached),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mismatches       (mismatch_count),
        .pending          (pending),
        .headings_checked (headings_checked),
        .reached_seen     (reached_seen)
    );

    // Receiver backpressure: runs of stall, mostly short, a few long
    always @(negedge clk)
    begin
        if (stall_left == 0 && stall_mode != 0)
        begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < ((stall_mode == 1) ? 15 : 40))
                stall_left = (stall_roll < 3) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        end
        out_stall <= (stall_left > 0);
        if (stall_left > 0)
            stall_left--;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one sample; starts and returns on a falling edge
    task automatic send_sample(logic [15:0] x, logic [15:0] y, logic [15:0] target);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid       <= 1'b1;
        field_x        <= x;
        field_y        <= y;
        target_heading <= target;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        samples_sent++;
    endtask

    // Hold the sender until every outstanding heading has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // Leaves cfg_valid high; the caller lowers it after the last write
    task automatic cfg_write(logic [chm_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic random_burst(int count, bit hold_mid);
        int kind;
        int v;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] t;
        for (int n = 0; n < count; n++)
        begin
            if (hold_mid && n == count / 2)
                wait_drained();
            kind = $urandom_range(0, 99);
            if (kind < 70)
            begin
                x = 16'($urandom);
                y = 16'($urandom);
            end
            else if (kind < 85)
            begin
                // tiny vectors near the origin, zero vector included
                v = $urandom_range(0, 8);
                x = 16'(v - 4);
                v = $urandom_range(0, 8);
                y = 16'(v - 4);
            end
            else
            begin
                // one coordinate zero or full scale, the other random or full scale
                v = $urandom_range(0, 3);
                x = (v == 0) ? 16'h8000 : (v == 1) ? 16'h7FFF : 16'($urandom);
                y = ($urandom_range(0, 1) == 1) ? 16'h0000 : ((v[0]) ? 16'h8000 : 16'h7FFF);
                if ($urandom_range(0, 1) == 1)
                begin
                    t = x;
                    x = y;
                    y = t;
                end
            end
            kind = $urandom_range(0, 99);
            if (kind < 70)
                t = 16'($urandom_range(0, 36000));
            else if (kind < 85)
                t = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(0, 600))
                                                : 16'($urandom_range(35400, 36000));
            else
                t = 16'($urandom);
            send_sample(x, y, t);
        end
    endtask

    // New register setting on an idle block, then a random burst
    task automatic run_phase(int k, logic [15:0] decl, logic [15:0] band);
        wait_drained();
        cfg_write(chm_pkg::REG_DECLINATION, decl);
        cfg_write(chm_pkg::REG_DEADBAND, band);
        if (k == 3)
        begin
            // unmapped indexes must leave both registers alone
            cfg_write(REG_SPARE_LO, 16'($urandom));
            cfg_write(REG_SPARE_HI, 16'($urandom));
        end
        cfg_valid    <= 1'b0;
        settings_run++;
        stall_mode = k % 3;
        quiet      = (k % 4 == 1);
        random_burst(PHASE_ITEMS, k == 2);
    endtask

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed samples at reset register values (declination 1261, band 500)
        send_sample(0, 0, 0);                      // zero vector
        send_sample(0, 0, 36000);
        send_sample(16'h7FFF, 0, 1261);
        send_sample(16'h8000, 0, 19261);           // negative x on the axis
        send_sample(0, 16'h7FFF, 16'hFFFF);        // target above full circle
        send_sample(0, 16'h8000, 0);
        send_sample(16'h7FFF, 16'h7FFF, 0);
        send_sample(16'h8000, 16'h8000, 36000);
        send_sample(16'h8000, 16'h7FFF, 20000);
        send_sample(16'h7FFF, 16'h8000, 36001);
        send_sample(16'hFFFF, 0, 0);
        send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_sample(1, 16'hFFFF, 500);
        send_sample(16'hFFFF, 1, 0);
        send_sample(1, 0, 761);                    // error exactly at the band edge
        send_sample(1, 0, 760);
        send_sample(1, 0, 1761);
        send_sample(1, 0, 1762);
        send_sample(0, 16'hFFFF, 28261);
        random_burst(60, 1'b0);

        // Register sweep: range extremes, 16-bit extremes, bit 15 of band set
        run_phase(1, 16'(-18000), 16'd0);
        run_phase(2, 16'd18000, 16'h7FFF);
        run_phase(3, 16'd32767, 16'd500);
        run_phase(4, 16'h8000, 16'h8000 | 16'd123);
        run_phase(5, 16'd0, 16'd18000);
        run_phase(6, 16'($urandom_range(0, 36000) - 18000), 16'($urandom));
        run_phase(7, 16'($urandom_range(0, 36000) - 18000), 16'($urandom_range(0, 18000)));
        run_phase(8, 16'd1261, 16'd500);

        in_valid <= 1'b0;
        for (int n = 0; n < DRAIN_LIMIT && pending != 0; n++)
            @(negedge clk);
        repeat (2 * DUT_LATENCY) @(negedge clk);

        $display("Covered %0d samples under %0d register settings with random gaps and stalls.",
                 samples_sent, settings_run);
        $display("Checked %0d headings, %0d of them flagged as reached; %0d mismatches.",
                 headings_checked, reached_seen, mismatch_count);
        if (mismatch_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #4000000;
        $display("Verification failed");
        $finish;
    end

endmodule

>>> filelist.f
src/chm_pkg.sv
src/compass_heading_from_magnetometer_core.sv
src/chm_checker.sv
bench/heading_checker.sv
bench/testbench.sv
